@@ design/ffha_pkg.sv @@
package ffha_pkg;

    localparam int unsigned HeapBytesDef   = 1024 * 1024 * 32;
    localparam int unsigned HeaderBytesDef = 16;
    localparam int unsigned MaxSegmentsDef = 64;

    localparam int unsigned AddrW = 26;
    localparam int unsigned StatW = 3;

    localparam logic [StatW-1:0] ST_OK      = 3'd0;
    localparam logic [StatW-1:0] ST_ZERO    = 3'd1;
    localparam logic [StatW-1:0] ST_NOFIT   = 3'd2;
    localparam logic [StatW-1:0] ST_FULL    = 3'd3;
    localparam logic [StatW-1:0] ST_IGNORED = 3'd4;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [AddrW-1:0] request_bytes;
        logic [AddrW-1:0] free_offset;
    } t_in_item;

    typedef struct packed {
        logic [AddrW-1:0] payload_offset;
        logic [StatW-1:0] status;
    } t_out_item;

    typedef enum logic [3:0] {
        DP_NOP   = 4'd0,
        DP_LOAD  = 4'd1,
        DP_RDCUR = 4'd2,
        DP_RDNXT = 4'd3,
        DP_SHUP  = 4'd4,
        DP_SPLIT = 4'd5,
        DP_MARK  = 4'd6,
        DP_SHDN  = 4'd7,
        DP_MPREV = 4'd8,
        DP_MNEXT = 4'd9,
        DP_DEC   = 4'd10,
        DP_STEP  = 4'd11,
        DP_RDDN  = 4'd12
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic             cur_used;
        logic             hit_exact;
        logic             hit_big;
        logic             hit_off;
        logic             at_end;
        logic             at_first;
        logic             shift_done;
        logic             full;
        logic             last_seg;
        logic             nxt_used;
        logic             prv_used;
        logic             req_zero;
        logic             kind;
        logic [AddrW-1:0] grant;
    } t_dp_stat;

endpackage

@@ design/ffha_datapath.sv @@
module ffha_datapath #(
    parameter int unsigned HEAP_BYTES   = 33554432,
    parameter int unsigned HEADER_BYTES = 16,
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffha_pkg::t_in_item  i_item,
    input  ffha_pkg::t_dp_cmd   i_cmd,
    output ffha_pkg::t_dp_stat  o_stat
);
    import ffha_pkg::*;

    localparam int unsigned IdxW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [AddrW:0] HeaderW = (AddrW + 1)'(HEADER_BYTES);

    logic [AddrW-1:0] mem_start [MAX_SEGMENTS];
    logic [AddrW-1:0] mem_size  [MAX_SEGMENTS];
    logic             mem_used  [MAX_SEGMENTS];

    logic [CntW-1:0]  r_count;
    logic [IdxW-1:0]  r_idx;
    logic [IdxW-1:0]  r_k;
    logic             r_kind;
    logic [AddrW:0]   r_need;
    logic [AddrW-1:0] r_off;
    logic [AddrW-1:0] r_cs, r_cz, r_ns, r_nz;
    logic             r_cu, r_nu, r_pu;
    logic [AddrW-1:0] r_ps, r_pz;
    logic [AddrW-1:0] r_grant;
    logic             r_init;

    logic [IdxW-1:0]  w_idx;
    logic [AddrW-1:0] w_start, w_size;
    logic             w_used, w_en;
    logic [IdxW-1:0]  rd_idx;
    logic [AddrW:0]   cur_sz_ext;

    assign cur_sz_ext = {1'b0, r_cz};

    always_comb begin
        w_en    = 1'b0;
        w_idx   = r_idx;
        w_start = r_cs;
        w_size  = r_cz;
        w_used  = r_cu;
        rd_idx  = r_idx;
        unique case (i_cmd.op)
            DP_RDCUR: rd_idx = r_idx;
            DP_RDNXT: rd_idx = r_k;
            DP_RDDN: rd_idx = r_k + IdxW'(1);
            DP_SHUP: begin
                w_en = 1'b1; w_idx = r_k + IdxW'(1);
                w_start = r_ns; w_size = r_nz; w_used = r_nu;
            end
            DP_SPLIT: begin
                w_en = 1'b1; w_idx = r_idx + IdxW'(1);
                w_start = AddrW'({1'b0, r_cs} + r_need);
                w_size  = AddrW'(cur_sz_ext - r_need);
                w_used  = 1'b0;
            end
            DP_MARK: begin
                w_en = 1'b1; w_idx = r_idx;
                w_start = r_cs;
                w_size  = (r_kind == KIND_ALLOC) ? AddrW'(r_need) : r_cz;
                w_used  = r_kind == KIND_ALLOC;
            end
            DP_SHDN: begin
                w_en = 1'b1; w_idx = r_k;
                w_start = r_ns; w_size = r_nz; w_used = r_nu;
            end
            DP_MPREV: begin
                w_en = 1'b1; w_idx = r_idx - IdxW'(1);
                w_start = r_ps; w_size = r_pz + r_cz; w_used = 1'b0;
            end
            DP_MNEXT: begin
                w_en = 1'b1; w_idx = r_idx;
                w_start = r_cs; w_size = r_cz + r_nz; w_used = 1'b0;
            end
            default: ;
        endcase
    end

    // Entry 0 is seeded on the first cycle after reset via a write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b1;
        end else begin
            r_init <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_init) begin
            mem_start[0] <= '0;
            mem_size[0]  <= AddrW'(HEAP_BYTES);
            mem_used[0]  <= 1'b0;
        end else if (w_en) begin
            mem_start[w_idx] <= w_start;
            mem_size[w_idx]  <= w_size;
            mem_used[w_idx]  <= w_used;
        end
        if (i_cmd.op == DP_RDCUR) begin
            r_cs <= mem_start[rd_idx];
            r_cz <= mem_size[rd_idx];
            r_cu <= mem_used[rd_idx];
        end
        if (i_cmd.op == DP_RDNXT || i_cmd.op == DP_RDDN) begin
            r_ns <= mem_start[rd_idx];
            r_nz <= mem_size[rd_idx];
            r_nu <= mem_used[rd_idx];
        end
        if (i_cmd.op == DP_MPREV) begin
            r_cs <= r_ps;
            r_cz <= r_pz + r_cz;
        end
        if (i_cmd.op == DP_MNEXT) begin
            r_cz <= r_cz + r_nz;
        end
        if (i_cmd.op == DP_MARK) begin
            r_cu <= r_kind == KIND_ALLOC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CntW'(1);
            r_idx   <= '0;
            r_k     <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_NOP: ;
                DP_LOAD: begin
                    r_kind  <= i_item.kind;
                    r_need  <= {1'b0, i_item.request_bytes} + HeaderW;
                    r_off   <= i_item.free_offset;
                    r_idx   <= '0;
                    r_pu    <= 1'b1;
                    r_grant <= '0;
                end
                DP_RDCUR: r_k <= IdxW'(r_count - CntW'(1));
                DP_RDNXT: ;
                DP_RDDN: ;
                DP_SHUP: r_k <= r_k - IdxW'(1);
                DP_SPLIT: r_count <= r_count + CntW'(1);
                DP_MARK: begin
                    if (r_kind == KIND_ALLOC) begin
                        r_grant <= AddrW'({1'b0, r_cs} + HeaderW);
                    end
                    r_k <= r_idx + IdxW'(1);
                end
                DP_SHDN: r_k <= r_k + IdxW'(1);
                DP_MPREV: begin
                    r_idx <= r_idx - IdxW'(1);
                    r_k   <= r_idx;
                end
                DP_MNEXT: ;
                DP_DEC: begin
                    r_count <= r_count - CntW'(1);
                    r_k     <= r_idx + IdxW'(1);
                end
                DP_STEP: begin
                    r_idx <= r_idx + IdxW'(1);
                    r_pu  <= r_cu;
                    r_ps  <= r_cs;
                    r_pz  <= r_cz;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.cur_used   = r_cu;
    assign o_stat.hit_exact  = cur_sz_ext == r_need;
    assign o_stat.hit_big    = cur_sz_ext > r_need;
    assign o_stat.hit_off    = ({1'b0, r_cs} + HeaderW) == {1'b0, r_off};
    assign o_stat.at_end     = ({1'b0, r_idx} + (CntW+1)'(1)) >= (CntW+1)'(r_count);
    assign o_stat.at_first   = r_idx == '0;
    assign o_stat.shift_done = r_kind == KIND_ALLOC ? (r_k == r_idx)
                             : ((CntW'(r_k) + CntW'(1)) >= r_count);
    assign o_stat.full       = r_count >= CntW'(MAX_SEGMENTS);
    assign o_stat.last_seg   = ({1'b0, r_idx} + (CntW+1)'(1)) >= (CntW+1)'(r_count);
    assign o_stat.nxt_used   = r_nu;
    assign o_stat.prv_used   = r_pu;
    assign o_stat.req_zero   = r_need == HeaderW;
    assign o_stat.kind       = r_kind;
    assign o_stat.grant      = r_grant;

endmodule

@@ design/ffha_ctrl.sv @@
module ffha_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ffha_pkg::t_out_item o_out_item,
    input  ffha_pkg::t_dp_stat  i_stat,
    output ffha_pkg::t_dp_cmd   o_cmd
);
    import ffha_pkg::*;

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_READ  = 13'b0000000000100,
        S_TEST  = 13'b0000000001000,
        S_SHRD  = 13'b0000000010000,
        S_SHWR  = 13'b0000000100000,
        S_SPLIT = 13'b0000001000000,
        S_MARK  = 13'b0000010000000,
        S_NXRD  = 13'b0000100000000,
        S_MERGE = 13'b0001000000000,
        S_DNRD  = 13'b0010000000000,
        S_DNWR  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state           r_state, n_state;
    logic             r_vld;
    t_out_item        r_out, n_out;
    t_out_item        r_res, n_res;
    logic             r_step, n_step;
    logic             r_dnext, n_dnext;
    logic             fin;

    assign o_out_valid = r_vld;
    assign o_out_item  = r_out;
    assign o_in_stall  = (r_state != S_IDLE) || (r_vld && i_out_stall);

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_res   = r_res;
        n_step  = r_step;
        n_dnext = r_dnext;
        fin     = 1'b0;
        o_cmd.op = DP_NOP;
        unique case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                o_cmd.op = DP_RDCUR;
                n_state  = S_TEST;
            end
            S_TEST: begin
                if (i_stat.kind == KIND_ALLOC) begin
                    if (i_stat.req_zero) begin
                        n_res = '{payload_offset: '0, status: ST_ZERO}; fin = 1'b1;
                    end else if (!i_stat.cur_used && i_stat.hit_exact) begin
                        n_state = S_MARK;
                    end else if (!i_stat.cur_used && i_stat.hit_big) begin
                        if (i_stat.full) begin
                            n_res = '{payload_offset: '0, status: ST_FULL}; fin = 1'b1;
                        end else begin
                            n_state = S_SHRD;
                        end
                    end else if (i_stat.at_end) begin
                        n_res = '{payload_offset: '0, status: ST_NOFIT}; fin = 1'b1;
                    end else begin
                        o_cmd.op = DP_STEP;
                        n_state  = S_READ;
                    end
                end else begin
                    if (i_stat.hit_off) begin
                        if (!i_stat.cur_used) begin
                            n_res = '{payload_offset: '0, status: ST_IGNORED}; fin = 1'b1;
                        end else begin
                            n_state = S_MARK;
                        end
                    end else if (i_stat.at_end) begin
                        n_res = '{payload_offset: '0, status: ST_IGNORED}; fin = 1'b1;
                    end else begin
                        o_cmd.op = DP_STEP;
                        n_state  = S_READ;
                    end
                end
                if (fin) begin
                    n_state = S_DONE;
                end
            end
            S_SHRD: begin
                if (i_stat.shift_done) begin
                    n_state = S_SPLIT;
                end else begin
                    o_cmd.op = DP_RDNXT;
                    n_state  = S_SHWR;
                end
            end
            S_SHWR: begin
                if (i_stat.kind == KIND_ALLOC) begin
                    o_cmd.op = DP_SHUP;
                    n_state  = S_SHRD;
                end else begin
                    o_cmd.op = DP_SHDN;
                    n_state  = S_DNWR;
                end
            end
            S_SPLIT: begin
                o_cmd.op = DP_SPLIT;
                n_state  = S_MARK;
            end
            S_MARK: begin
                o_cmd.op = DP_MARK;
                n_step   = 1'b0;
                n_dnext  = 1'b0;
                n_state  = i_stat.kind == KIND_ALLOC ? S_DONE : S_MERGE;
                n_res    = '{payload_offset: '0, status: ST_OK};
            end
            S_MERGE: begin
                if (!r_step) begin
                    n_step = 1'b1;
                    if (!i_stat.at_first && !i_stat.prv_used) begin
                        o_cmd.op = DP_MPREV;
                        n_dnext  = 1'b0;
                        n_state  = S_DNRD;
                    end else begin
                        n_state = S_NXRD;
                    end
                end else begin
                    n_state = S_NXRD;
                end
            end
            S_NXRD: begin
                if (i_stat.last_seg || r_dnext) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = DP_RDNXT;
                    n_dnext  = 1'b1;
                    n_state  = S_DNRD;
                end
            end
            S_DNRD: begin
                if (!r_dnext) begin
                    n_state = S_DNWR;
                end else if (i_stat.nxt_used) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = DP_MNEXT;
                    n_state  = S_DNWR;
                end
            end
            S_DNWR: begin
                if (i_stat.shift_done) begin
                    o_cmd.op = DP_DEC;
                    n_state  = r_dnext ? S_DONE : S_NXRD;
                end else begin
                    o_cmd.op = DP_RDDN;
                    n_state  = S_SHWR;
                end
            end
            S_DONE: begin
                n_out = r_res;
                if (i_stat.kind == KIND_ALLOC && r_res.status == ST_OK) begin
                    n_out.payload_offset = i_stat.grant;
                end
                if (!r_vld || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_vld   <= 1'b0;
            r_step  <= 1'b0;
            r_dnext <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_dnext <= n_dnext;
            if (r_state == S_DONE && (!r_vld || !i_out_stall)) begin
                r_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == S_DONE && (!r_vld || !i_out_stall)) begin
            r_out <= n_out;
        end
    end

endmodule

@@ design/first_fit_heap_allocator.sv @@
// First-fit heap allocator with coalescing over an address-ordered segment table.
// Input channel: i_in_valid / o_in_stall with an ffha_pkg::t_in_item payload
// (kind 0 allocates request_bytes, kind 1 frees free_offset). A transfer
// happens at a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with a t_out_item holding the
// payload offset and a status code. Every input transfer yields one result.
// An item reads and then compares each segment scanned, in address order;
// a split or merge then moves table entries one by one, each with a read
// and a write. The segment table memory takes one read or one write a cycle.
// Items are handled one at a time. The result sits in an output register;
// while the receiver stalls, no new item is taken, but one already under way
// is finished and then waits for the register to drain before presenting it.
// Reset is synchronous and active low; after S_INIT the table holds a single
// free segment covering the heap and the block accepts input.
module first_fit_heap_allocator #(
    parameter int unsigned HEAP_BYTES   = ffha_pkg::HeapBytesDef,
    parameter int unsigned HEADER_BYTES = ffha_pkg::HeaderBytesDef,
    parameter int unsigned MAX_SEGMENTS = ffha_pkg::MaxSegmentsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ffha_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ffha_pkg::t_out_item o_out_item
);
    import ffha_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ffha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

@@ tb/ffha_checker.sv @@
module ffha_checker #(
    parameter int unsigned HEAP_BYTES   = ffha_pkg::HeapBytesDef,
    parameter int unsigned HEADER_BYTES = ffha_pkg::HeaderBytesDef,
    parameter int unsigned MAX_SEGMENTS = ffha_pkg::MaxSegmentsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  ffha_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  ffha_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import ffha_pkg::*;

    logic [31:0] seg_base [MAX_SEGMENTS];
    logic [31:0] seg_len  [MAX_SEGMENTS];
    logic        seg_busy [MAX_SEGMENTS];
    int          seg_num;
    t_out_item   expected_results [$];

    function automatic void remove_segment(int idx);
        for (int k = idx; k + 1 < seg_num; k++) begin
            seg_base[k] = seg_base[k + 1];
            seg_len[k]  = seg_len[k + 1];
            seg_busy[k] = seg_busy[k + 1];
        end
        seg_num--;
    endfunction

    function automatic t_out_item heap_step(t_in_item item);
        t_out_item   res;
        logic [31:0] need;
        logic [31:0] off;
        int          i;
        res.payload_offset = '0;
        res.status = ST_OK;
        if (item.kind == KIND_ALLOC) begin
            need = 32'(item.request_bytes) + HEADER_BYTES;
            if (item.request_bytes == 0) begin
                res.status = ST_ZERO;
                return res;
            end
            for (i = 0; i < seg_num; i++) begin
                if (seg_busy[i]) continue;
                if (seg_len[i] == need) begin
                    seg_busy[i] = 1'b1;
                    res.payload_offset = AddrW'(seg_base[i] + HEADER_BYTES);
                    return res;
                end
                if (seg_len[i] > need) begin
                    if (seg_num >= MAX_SEGMENTS) begin
                        res.status = ST_FULL;
                        return res;
                    end
                    for (int k = seg_num; k > i + 1; k--) begin
                        seg_base[k] = seg_base[k - 1];
                        seg_len[k]  = seg_len[k - 1];
                        seg_busy[k] = seg_busy[k - 1];
                    end
                    seg_base[i + 1] = seg_base[i] + need;
                    seg_len[i + 1]  = seg_len[i] - need;
                    seg_busy[i + 1] = 1'b0;
                    seg_num++;
                    seg_len[i]  = need;
                    seg_busy[i] = 1'b1;
                    res.payload_offset = AddrW'(seg_base[i] + HEADER_BYTES);
                    return res;
                end
            end
            res.status = ST_NOFIT;
            return res;
        end
        off = 32'(item.free_offset);
        for (i = 0; i < seg_num; i++)
            if (seg_base[i] + HEADER_BYTES == off) break;
        if (i >= seg_num || !seg_busy[i]) begin
            res.status = ST_IGNORED;
            return res;
        end
        seg_busy[i] = 1'b0;
        if (i > 0 && !seg_busy[i - 1]) begin
            seg_len[i - 1] += seg_len[i];
            remove_segment(i);
            i--;
        end
        if (i + 1 < seg_num && !seg_busy[i + 1]) begin
            seg_len[i] += seg_len[i + 1];
            remove_segment(i + 1);
        end
        return res;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            seg_num = 1;
            seg_base[0] = 0;
            seg_len[0] = HEAP_BYTES;
            seg_busy[0] = 1'b0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("Unexpected result: offset %0d status %0d",
                                 i_out_item.payload_offset, i_out_item.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_out_item) begin
                        if (o_fail_count < 10)
                            $display("Mismatch: expected offset %0d status %0d, got %0d %0d",
                                     want.payload_offset, want.status,
                                     i_out_item.payload_offset, i_out_item.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(heap_step(i_in_item));
        end
    end
endmodule

@@ tb/tb_first_fit_heap_allocator.sv @@
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_cycles = 0;
    logic [25:0] granted [$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    first_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item)
    );

    ffha_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_item(input logic kind, input logic [25:0] req,
                             input logic [25:0] off);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= '{kind: kind, request_bytes: req, free_offset: off};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (kind == KIND_ALLOC) granted.push_back('0);
    endtask

    task automatic send_random;
        logic [25:0] req;
        logic [25:0] off;
        int          idx;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            case ($urandom_range(3))
                0: req = 26'($urandom_range(64, 1));
                1: req = 26'($urandom_range(4096, 1));
                2: req = 26'($urandom_range(1 << 20, 1));
                default: req = 26'($urandom);
            endcase
            send_item(KIND_ALLOC, req, 26'($urandom));
        end else if (pick < 88 && granted.size() > 0) begin
            idx = $urandom_range(granted.size() - 1);
            off = granted[idx];
            granted.delete(idx);
            send_item(KIND_FREE, 26'($urandom), off);
        end else begin
            off = 26'($urandom);
            if ($urandom_range(1)) off = {off[25:4], 4'h0};
            send_item(1'($urandom_range(1)), $urandom_range(1) ? 26'd0 : 26'($urandom),
                      off);
        end
    endtask

    always @(posedge i_clk)
        if (out_valid && !out_stall && out_item.status == ST_OK &&
            out_item.payload_offset != 0)
            granted.push_back(out_item.payload_offset);

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_item(KIND_ALLOC, 26'd0, 26'd0);
        send_item(KIND_FREE, 26'd0, 26'd16);
        send_item(KIND_ALLOC, 26'd33554416, 26'h3FFFFFF);
        send_item(KIND_FREE, 26'h3FFFFFF, 26'd16);
        send_item(KIND_FREE, 26'd0, 26'd16);
        send_item(KIND_ALLOC, 26'h3FFFFFF, 26'd0);
        send_item(KIND_ALLOC, 26'd33554417, 26'd0);
        send_item(KIND_ALLOC, 26'd100, 26'd0);
        send_item(KIND_ALLOC, 26'd200, 26'd0);
        send_item(KIND_ALLOC, 26'd300, 26'd0);
        send_item(KIND_FREE, 26'd0, 26'd16);
        send_item(KIND_FREE, 26'd0, 26'd16);
        send_item(KIND_FREE, 26'd0, 26'd17);
        send_item(KIND_ALLOC, 26'd100, 26'd0);
        send_item(KIND_FREE, 26'd0, 26'd132);
        send_item(KIND_FREE, 26'd0, 26'd348);
        send_item(KIND_FREE, 26'd0, 26'd16);
        for (int k = 0; k < 66; k++) send_item(KIND_ALLOC, 26'd1, 26'd0);
        in_valid <= 1'b0;
        drain();
        granted.delete();
        for (int k = 0; k < 63; k++) send_item(KIND_FREE, 26'd0, 26'(16 + 17 * k));

        send_idle_pct = 26;
        recv_idle_pct = 74;
        for (int k = 0; k < 500; k++) send_random();
        send_idle_pct = 74;
        recv_idle_pct = 26;
        for (int k = 0; k < 500; k++) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 2000;
        for (int k = 0; k < 450; k++) send_random();
        in_valid <= 1'b0;
        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ first_fit_heap_allocator.f @@
design/ffha_pkg.sv
design/ffha_datapath.sv
design/ffha_ctrl.sv
design/first_fit_heap_allocator.sv
tb/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
